// ===== sv/aarm_pkg.sv =====
// Shared types and elaboration-time constant helpers for the axis-angle
// rotation matrix block (CORDIC angle table, gain, pi in fixed point).
// No dependencies.
package aarm_pkg;

  localparam int FIELD_W  = 16;
  localparam int S_DATA_W = 4 * FIELD_W;
  localparam int M_DATA_W = 9 * FIELD_W;

  // pi * 2^60, truncated
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Unit axis, Q1.14 components
  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } axis_t;

  // Data that rides along the CORDIC chain
  typedef struct packed {
    axis_t axis;
    logic  flip;
  } pass_t;

  // Nine matrix entries, Q1.14 saturated
  typedef struct packed {
    logic signed [FIELD_W-1:0] c0r0;
    logic signed [FIELD_W-1:0] c0r1;
    logic signed [FIELD_W-1:0] c0r2;
    logic signed [FIELD_W-1:0] c1r0;
    logic signed [FIELD_W-1:0] c1r1;
    logic signed [FIELD_W-1:0] c1r2;
    logic signed [FIELD_W-1:0] c2r0;
    logic signed [FIELD_W-1:0] c2r1;
    logic signed [FIELD_W-1:0] c2r2;
  } result_t;

  // Restoring shift-subtract quotient, elaboration only (d < 2^63)
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Integer square root, digit by digit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = v;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(2^-i) in Q60: pi/4 for i = 0, else alternating Taylor series
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    sum = '0;
    if (i == 0) return PI_Q60 >> 2;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Round a Q60 value to Q.frac
  function automatic logic [63:0] to_frac(input logic [63:0] q60, input int frac);
    return (q60 + (64'd1 << (59 - frac))) >> (60 - frac);
  endfunction

  // Start value of x: reciprocal of the accumulated CORDIC gain, Q.frac
  function automatic logic [63:0] cordic_gain(input int stages, input int frac);
    logic [63:0] p;
    logic [63:0] s;
    p = 64'd1 << 62;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    s = isqrt64(p);
    return udiv64((64'd1 << (frac + 31)) + (s >> 1), s);
  endfunction

endpackage

// ===== sv/axis_angle_rotation_matrix.sv =====
// Pipeline: one angle-reduction stage, one register per CORDIC micro-rotation
// cell, four product/sum/saturate stages.
// Throughput: one item per cycle while the output takes results; every stage
// holds its own valid bit, so bubbles close up and input is taken while a result
// waits on the output, until every stage is full.
// Reset clears the valid bits and the in-flight count; data registers are not reset.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 14,
  parameter int FRAC_BITS     = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // angle, axis_x, axis_y, axis_z (16 bits each, from bit 0 up)
  input  logic [aarm_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2 (16 bits each, from bit 0 up)
  output logic [aarm_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import aarm_pkg::*;

  localparam int ZW  = FRAC_BITS + 4;
  localparam int XW  = FRAC_BITS + 3;
  localparam int TW  = FRAC_BITS + 20;
  localparam int SHL = (FRAC_BITS >= 13) ? FRAC_BITS - 13 : 0;
  localparam int SHR = (FRAC_BITS < 13) ? 13 - FRAC_BITS : 0;
  localparam int LAT = CORDIC_STAGES + 5;
  localparam int CW  = $clog2(LAT + 1) + 1;

  localparam logic [63:0]          PI_F   = to_frac(PI_Q60, FRAC_BITS);
  localparam logic signed [TW-1:0] PI_T   = PI_F[TW-1:0];
  localparam logic [63:0]          GAIN_F = cordic_gain(CORDIC_STAGES, FRAC_BITS);
  localparam logic signed [TW-1:0] A_RND  = (SHR > 0) ? (TW'(1) <<< (SHR - 1)) : '0;

  // input unpack
  logic signed [FIELD_W-1:0] angle;
  axis_t                     in_axis;
  assign angle     = s_axis_tdata[15:0];
  assign in_axis.x = s_axis_tdata[31:16];
  assign in_axis.y = s_axis_tdata[47:32];
  assign in_axis.z = s_axis_tdata[63:48];

  // angle to Q.F and reduction into [-pi/2, pi/2]
  logic signed [TW-1:0] a_w, z_s, z_r;
  logic                 flip;
  always_comb begin
    a_w  = TW'(angle);
    z_s  = ((a_w + A_RND) >>> SHR) <<< SHL;
    z_r  = z_s;
    flip = 1'b0;
    if ((z_s <<< 1) > PI_T) begin
      z_r  = z_s - PI_T;
      flip = 1'b1;
    end else if ((z_s <<< 1) < -PI_T) begin
      z_r  = z_s + PI_T;
      flip = 1'b1;
    end
  end

  // chain wiring: index g feeds cell g
  logic                 vld_w  [CORDIC_STAGES+1];
  logic                 rdy_w  [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_w    [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_w    [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_w    [CORDIC_STAGES+1];
  pass_t                pass_w [CORDIC_STAGES+1];

  // input register stage
  logic                 in_vld_q;
  logic signed [ZW-1:0] in_z_q;
  pass_t                in_pass_q;

  assign s_axis_tready = !in_vld_q || rdy_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_z_q         <= z_r[ZW-1:0];
      in_pass_q.axis <= in_axis;
      in_pass_q.flip <= flip;
    end
  end

  assign vld_w[0]  = in_vld_q;
  assign x_w[0]    = GAIN_F[XW-1:0];
  assign y_w[0]    = '0;
  assign z_w[0]    = in_z_q;
  assign pass_w[0] = in_pass_q;

  // CORDIC cell chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    localparam logic [63:0] AT_F = to_frac(atan_q60(g), FRAC_BITS);
    aarm_cordic_cell #(
      .XW    (XW),
      .ZW    (ZW),
      .SHIFT (g),
      .ATAN  (AT_F[ZW-1:0])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[g]),
      .ready_o (rdy_w[g]),
      .x_i     (x_w[g]),
      .y_i     (y_w[g]),
      .z_i     (z_w[g]),
      .pass_i  (pass_w[g]),
      .valid_o (vld_w[g+1]),
      .ready_i (rdy_w[g+1]),
      .x_o     (x_w[g+1]),
      .y_o     (y_w[g+1]),
      .z_o     (z_w[g+1]),
      .pass_o  (pass_w[g+1])
    );
  end

  // matrix entries
  result_t res;
  aarm_rodrigues #(
    .FRAC_BITS (FRAC_BITS),
    .XW        (XW)
  ) u_rodrigues (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_w[CORDIC_STAGES]),
    .ready_o  (rdy_w[CORDIC_STAGES]),
    .x_i      (x_w[CORDIC_STAGES]),
    .y_i      (y_w[CORDIC_STAGES]),
    .pass_i   (pass_w[CORDIC_STAGES]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res)
  );

  // output pack, first entry in the low bits
  assign m_axis_tdata = {res.c2r2, res.c2r1, res.c2r0,
                         res.c1r2, res.c1r1, res.c1r0,
                         res.c0r2, res.c0r1, res.c0r0};

  // items in flight
  logic [CW-1:0] cnt_q;
  logic          in_xfer, out_xfer;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // input stalls only when the whole pipe is backed up by the output
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // never more items in flight than pipeline registers
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LAT))
    else $error("pipeline occupancy exceeds stage count");

  // diagonal entries stay within the saturation bounds
  a_sat_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(res.c0r0) <= 16'sd16384 && $signed(res.c0r0) >= -16'sd16384
                    && $signed(res.c1r1) <= 16'sd16384 && $signed(res.c1r1) >= -16'sd16384
                    && $signed(res.c2r2) <= 16'sd16384 && $signed(res.c2r2) >= -16'sd16384))
    else $error("matrix entry outside saturation range");

endmodule

// ===== sv/aarm_cordic_cell.sv =====
// One CORDIC micro-rotation stage: shift-add on x/y, angle update on z.
// Depends on aarm_pkg (pass_t).
module aarm_cordic_cell #(
  parameter int                     XW    = 17,
  parameter int                     ZW    = 18,
  parameter int                     SHIFT = 0,
  parameter logic signed [ZW-1:0]   ATAN  = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  aarm_pkg::pass_t      pass_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output aarm_pkg::pass_t      pass_o
);
  import aarm_pkg::*;

  logic                 vld_q;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d;
  pass_t                pass_q;

  // rotate toward z = 0
  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = vld_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pass_o  = pass_q;

endmodule

// ===== sv/aarm_rodrigues.sv =====
// Rodrigues products: sin/cos sign fix, axis products, scaling by (1-cos)
// and sin, sums, rounding to Q1.14 and saturation. Four registered stages.
// Depends on aarm_pkg (pass_t, result_t).
module aarm_rodrigues #(
  parameter int FRAC_BITS = 14,
  parameter int XW        = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  aarm_pkg::pass_t      pass_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output aarm_pkg::result_t    result_o
);
  import aarm_pkg::*;

  localparam int PW = 2 * FIELD_W;   // axis product
  localparam int MW = PW + XW;       // product times (1-cos)
  localparam int UW = FIELD_W + XW;  // axis times sin
  localparam int SW = MW + 1;        // entry sum, Q.(28+F)
  localparam int RSH = 14 + FRAC_BITS;
  localparam logic signed [XW-1:0] ONE    = XW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] RND    = SW'(1) <<< (RSH - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'(16384);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(16384);

  // shift down and clamp one entry to Q1.14 (rounding offset is added in stage 3)
  function automatic logic signed [FIELD_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v >>> RSH;
    if (r > SAT_HI) return SAT_HI[FIELD_W-1:0];
    if (r < SAT_LO) return SAT_LO[FIELD_W-1:0];
    return r[FIELD_W-1:0];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  // stage 1: cos/sin, 1-cos, axis products
  logic signed [XW-1:0] c1_q, s1_q, omc1_q;
  logic signed [PW-1:0] xx1_q, yy1_q, zz1_q, xy1_q, xz1_q, yz1_q;
  axis_t                ax1_q;
  // stage 2: scaled products
  logic signed [XW-1:0] c2_q;
  logic signed [MW-1:0] mxx2_q, myy2_q, mzz2_q, mxy2_q, mxz2_q, myz2_q;
  logic signed [UW-1:0] sx2_q, sy2_q, sz2_q;
  // stage 3: sums
  logic signed [SW-1:0] sum3_q [9];
  // stage 4: output register
  result_t              res4_q;

  assign r4      = !v4_q || ready_i;
  assign r3      = !v3_q || r4;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      c1_q   <= pass_i.flip ? -x_i : x_i;
      s1_q   <= pass_i.flip ? -y_i : y_i;
      omc1_q <= pass_i.flip ? ONE + x_i : ONE - x_i;
      xx1_q  <= pass_i.axis.x * pass_i.axis.x;
      yy1_q  <= pass_i.axis.y * pass_i.axis.y;
      zz1_q  <= pass_i.axis.z * pass_i.axis.z;
      xy1_q  <= pass_i.axis.x * pass_i.axis.y;
      xz1_q  <= pass_i.axis.x * pass_i.axis.z;
      yz1_q  <= pass_i.axis.y * pass_i.axis.z;
      ax1_q  <= pass_i.axis;
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      c2_q   <= c1_q;
      mxx2_q <= xx1_q * omc1_q;
      myy2_q <= yy1_q * omc1_q;
      mzz2_q <= zz1_q * omc1_q;
      mxy2_q <= xy1_q * omc1_q;
      mxz2_q <= xz1_q * omc1_q;
      myz2_q <= yz1_q * omc1_q;
      sx2_q  <= ax1_q.x * s1_q;
      sy2_q  <= ax1_q.y * s1_q;
      sz2_q  <= ax1_q.z * s1_q;
    end
  end

  // stage 3: column-major entry sums with rounding offset
  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      sum3_q[0] <= SW'(mxx2_q) + (SW'(c2_q) <<< 28) + RND;
      sum3_q[1] <= SW'(mxy2_q) + (SW'(sz2_q) <<< 14) + RND;
      sum3_q[2] <= SW'(mxz2_q) - (SW'(sy2_q) <<< 14) + RND;
      sum3_q[3] <= SW'(mxy2_q) - (SW'(sz2_q) <<< 14) + RND;
      sum3_q[4] <= SW'(myy2_q) + (SW'(c2_q) <<< 28) + RND;
      sum3_q[5] <= SW'(myz2_q) + (SW'(sx2_q) <<< 14) + RND;
      sum3_q[6] <= SW'(mxz2_q) + (SW'(sy2_q) <<< 14) + RND;
      sum3_q[7] <= SW'(myz2_q) - (SW'(sx2_q) <<< 14) + RND;
      sum3_q[8] <= SW'(mzz2_q) + (SW'(c2_q) <<< 28) + RND;
    end
  end

  // stage 4: shift down and saturate
  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      res4_q.c0r0 <= sat(sum3_q[0]);
      res4_q.c0r1 <= sat(sum3_q[1]);
      res4_q.c0r2 <= sat(sum3_q[2]);
      res4_q.c1r0 <= sat(sum3_q[3]);
      res4_q.c1r1 <= sat(sum3_q[4]);
      res4_q.c1r2 <= sat(sum3_q[5]);
      res4_q.c2r0 <= sat(sum3_q[6]);
      res4_q.c2r1 <= sat(sum3_q[7]);
      res4_q.c2r2 <= sat(sum3_q[8]);
    end
  end

  assign valid_o  = v4_q;
  assign result_o = res4_q;

endmodule

// ===== bench/axis_angle_rotation_matrix_test.sv =====
// Self-checking bench for axis_angle_rotation_matrix: streams angle/axis items,
// predicts the nine rotation entries (CORDIC sin/cos plus axis-angle products).
// Depends on aarm_pkg (data widths) and the axis_angle_rotation_matrix RTL.
module axis_angle_rotation_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES       = 14;
  localparam int FRAC         = 14;
  localparam int LATENCY      = STAGES + 5;
  localparam int RANDOM_ITEMS = 630;
  localparam int CALM_ITEMS   = 120;
  localparam int LIMIT_CYCLES = 200000;
  localparam int ONE          = 16384;   // 1.0 in Q1.14
  localparam int HALF_PI_EDGE = 12868;   // largest Q3.13 angle not folded by pi
  localparam int PI_Q13       = 25736;
  localparam logic [63:0] PI_SCALED = 64'h3243F6A8885A308D;  // pi * 2^60

  // Entry k sits in bits [16k+15:16k], same order as the output tdata
  typedef logic [8:0][15:0] matrix_t;

  // Predicts each matrix from the accepted item and checks results in order
  class rotation_scoreboard;
    matrix_t pending_matrices[$];
    longint  atan_table[STAGES];
    longint  pi_fixed;
    longint  gain;
    int      errors;
    string   entry_names[9] = '{"c0r0", "c0r1", "c0r2", "c1r0", "c1r1", "c1r2",
                                "c2r0", "c2r1", "c2r2"};

    function new();
      longint unsigned p;
      longint unsigned root;
      errors   = 0;
      pi_fixed = round_q60(PI_SCALED);
      for (int i = 0; i < STAGES; i++) atan_table[i] = round_q60(atan_q60(i));
      // inverse CORDIC gain: 2^(FRAC+31) / sqrt(2^62 * prod(1 + 4^-i))
      p = 64'd1 << 62;
      for (int i = 0; i < STAGES; i++) p = p + (p >> (2 * i));
      root = floor_sqrt(p);
      gain = longint'(((64'd1 << (FRAC + 31)) + root / 2) / root);
    endfunction

    function longint round_q60(longint unsigned q60);
      return longint'((q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
    endfunction

    // atan(2^-i) in Q60: pi/4 at i = 0, else the truncated Taylor series
    function longint unsigned atan_q60(int i);
      longint unsigned acc;
      longint unsigned term;
      int              e;
      acc = 0;
      if (i == 0) return PI_SCALED >> 2;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      return acc;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // pr is Q.28, omc and diag Q.FRAC, sv Q.(14+FRAC); round to Q1.14, clamp to +-1
    function logic [15:0] mat_entry(longint pr, longint omc, longint diag, longint sv);
      longint acc;
      longint r;
      acc = pr * omc + diag * (longint'(1) << 28) + sv * (longint'(1) << 14);
      r   = (acc + (longint'(1) << (13 + FRAC))) >>> (14 + FRAC);
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      return r[15:0];
    endfunction

    function matrix_t predict_matrix(logic signed [15:0] angle, logic signed [15:0] ax,
                                     logic signed [15:0] ay, logic signed [15:0] az);
      longint  z, x, y, xs, ys, c, s, omc, ux, uy, uz;
      bit      flip;
      matrix_t m;
      ux   = ax;
      uy   = ay;
      uz   = az;
      z    = longint'(angle) <<< (FRAC - 13);
      flip = 1'b0;
      // fold into [-pi/2, pi/2], negate sin and cos afterwards
      if (2 * z > pi_fixed) begin
        z    = z - pi_fixed;
        flip = 1'b1;
      end else if (2 * z < -pi_fixed) begin
        z    = z + pi_fixed;
        flip = 1'b1;
      end
      x = gain;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_table[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_table[i];
        end
      end
      c   = flip ? -x : x;
      s   = flip ? -y : y;
      omc = (longint'(1) << FRAC) - c;
      m[0] = mat_entry(ux * ux, omc, c, 0);
      m[1] = mat_entry(uy * ux, omc, 0, uz * s);
      m[2] = mat_entry(uz * ux, omc, 0, -(uy * s));
      m[3] = mat_entry(ux * uy, omc, 0, -(uz * s));
      m[4] = mat_entry(uy * uy, omc, c, 0);
      m[5] = mat_entry(uz * uy, omc, 0, ux * s);
      m[6] = mat_entry(ux * uz, omc, 0, uy * s);
      m[7] = mat_entry(uy * uz, omc, 0, -(ux * s));
      m[8] = mat_entry(uz * uz, omc, c, 0);
      return m;
    endfunction

    function void note_input(logic [15:0] angle, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az);
      pending_matrices.push_back(predict_matrix(angle, ax, ay, az));
    endfunction

    function int pending_count();
      return pending_matrices.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(matrix_t got);
      matrix_t want;
      if (pending_matrices.size() == 0) begin
        report("result transfer with no item outstanding");
        return;
      end
      want = pending_matrices.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got[k] !== want[k])
          report($sformatf("%s got %0d expected %0d", entry_names[k],
                           $signed(got[k]), $signed(want[k])));
      end
    endtask
  endclass

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [aarm_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [aarm_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                            idle_on       = 1'b1;
  int unsigned                     stall_left    = 0;
  int unsigned                     cycle_count   = 0;
  rotation_scoreboard              sb            = new();

  axis_angle_rotation_matrix #(
    .CORDIC_STAGES (STAGES),
    .FRAC_BITS     (FRAC)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each transfer, then stall tready in random bursts while idle_on is set
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One input transfer, optionally preceded by an idle burst
  task automatic send_item(logic [15:0] angle, logic [15:0] ax, logic [15:0] ay,
                           logic [15:0] az);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {az, ay, ax, angle};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(angle, ax, ay, az);
  endtask

  // Hold off the sender until every outstanding matrix has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  function automatic logic [15:0] pick_angle();
    int v;
    case ($urandom_range(0, 9))
      0: v = HALF_PI_EDGE + int'($urandom_range(0, 4)) - 2;
      1: v = PI_Q13 + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return 16'(v);
  endfunction

  // Mostly unit axes; some non-unit in range, some with arbitrary bits
  task automatic pick_axis(output logic [15:0] ax, output logic [15:0] ay,
                           output logic [15:0] az);
    real vx, vy, vz, len;
    int  sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      vx = $itor($urandom_range(0, 65535)) - 32768.0;
      vy = $itor($urandom_range(0, 65535)) - 32768.0;
      vz = $itor($urandom_range(0, 65535)) - 32768.0;
      if ($urandom_range(0, 3) == 0) vz = 0.0;
      if ($urandom_range(0, 5) == 0) vy = 0.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      if (len < 1.0) begin
        vx  = 1.0;
        len = 1.0;
      end
      ax = 16'($rtoi(vx / len * 16384.0));
      ay = 16'($rtoi(vy / len * 16384.0));
      az = 16'($rtoi(vz / len * 16384.0));
    end else if (sel < 8) begin
      ax = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
      ay = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
      az = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
    end else begin
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
    end
  endtask

  // Cardinal axes, fold edges at +-pi/2 and +-pi, full-scale and non-unit axes
  task automatic run_directed();
    send_item(16'd0,             16'(ONE), 16'd0, 16'd0);
    send_item(16'd0,             16'd0, 16'd0, 16'(ONE));
    send_item(16'sd32767,        16'(ONE), 16'd0, 16'd0);
    send_item(-16'sd32768,       16'd0, 16'(ONE), 16'd0);
    send_item(16'(HALF_PI_EDGE), 16'd0, 16'd0, 16'(ONE));
    send_item(16'(HALF_PI_EDGE + 1), 16'd0, 16'd0, 16'(ONE));
    send_item(16'(-HALF_PI_EDGE),    16'(ONE), 16'd0, 16'd0);
    send_item(16'(-HALF_PI_EDGE - 1), 16'(ONE), 16'd0, 16'd0);
    send_item(16'(PI_Q13),       16'd0, 16'(ONE), 16'd0);
    send_item(16'(-PI_Q13),      16'd0, 16'd0, 16'(-ONE));
    send_item(16'sd6434,         16'sd9459, 16'sd9459, 16'sd9459);
    send_item(16'(HALF_PI_EDGE), 16'(-ONE), 16'd0, 16'd0);
    send_item(-16'sd32768,       -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(16'sd32767,        16'sd32767, 16'sd32767, 16'sd32767);
    send_item(16'sd20000,        16'(ONE), 16'(ONE), 16'(ONE));
    send_item(-16'sd20000,       16'(-ONE), 16'(ONE), 16'(-ONE));
    send_item(16'sd8192,         16'd0, 16'd0, 16'd0);
    send_item(-16'sd1,           16'sd11585, 16'sd11585, 16'd0);
    send_item(16'sd1,            16'd0, -16'sd11585, 16'sd11585);
    send_item(16'sd16000,        -16'sd32768, 16'd0, 16'(ONE));
    send_item(-16'sd16000,       16'd0, 16'(-ONE), 16'd0);
    send_item(16'(HALF_PI_EDGE + 1), 16'd0, 16'd0, 16'(-ONE));
  endtask

  initial begin
    logic [15:0] angle, ax, ay, az;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_drained();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      angle = pick_angle();
      pick_axis(ax, ay, az);
      send_item(angle, ax, ay, az);
    end
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== axis_angle_rotation_matrix.f =====
sv/aarm_pkg.sv
sv/aarm_cordic_cell.sv
sv/aarm_rodrigues.sv
sv/axis_angle_rotation_matrix.sv
bench/axis_angle_rotation_matrix_test.sv
